/* hdl/cbu_pkg.sv */
// Shared constants of the conditional branch unit: sizes, operation, kind and mode codes.
`default_nettype none

package cbu_pkg;

  // Word memory size and its address width.
  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  // Register file geometry; register 6 is the program counter.
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_AW    = 3;
  localparam logic [REG_AW-1:0] PC_INDEX = 3'd6;

  // Data width and the auto increment step.
  localparam int unsigned DATA_W = 16;
  localparam logic [DATA_W-1:0] STEP     = 16'd2;
  localparam logic [DATA_W-1:0] NEG_STEP = 16'hFFFE;

  // Operation codes.
  localparam logic [1:0] OP_BRANCH    = 2'd0;
  localparam logic [1:0] OP_WRITE_REG = 2'd1;
  localparam logic [1:0] OP_WRITE_MEM = 2'd2;
  localparam logic [1:0] OP_NONE      = 2'd3;

  // Branch kinds.
  localparam logic [3:0] BK_CC     = 4'd0;
  localparam logic [3:0] BK_CS     = 4'd1;
  localparam logic [3:0] BK_EQ     = 4'd2;
  localparam logic [3:0] BK_NE     = 4'd3;
  localparam logic [3:0] BK_LT     = 4'd4;
  localparam logic [3:0] BK_LE     = 4'd5;
  localparam logic [3:0] BK_GT     = 4'd6;
  localparam logic [3:0] BK_GE     = 4'd7;
  localparam logic [3:0] BK_ALWAYS = 4'd8;

  // Displacement addressing modes.
  localparam logic [2:0] MODE_REG     = 3'd0;
  localparam logic [2:0] MODE_PREDEC  = 3'd1;
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_IMM     = 3'd4;

endpackage

`default_nettype wire

/* hdl/conditional_branch_unit.sv */
// Conditional branch unit: register file, word memory and a sequenced shared adder.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | op, branch_kind, mode, operand, flags, load_*
//  out     | output    | out_valid_o/out_stall_i | program_counter, taken, base_register
//
// Steps: loads, untaken branches and modes five to seven go straight to the final step; modes 0
// and 4 add; indirect reads, then adds; pre-decrement decrements, reads, adds; post-increment
// reads, adds, increments, as the one shared 16-bit adder and registered memory read require.
// One item is in work at a time; the result waits in the output register while the next
// item is accepted, and the sequencer holds its last step while that register is stalled.
// Reset clears the register file and the control state; memory words are undefined until written.
`default_nettype none

module conditional_branch_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [3:0]  branch_kind_i,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  operand_i,
  input  wire logic        carry_flag_i,
  input  wire logic        zero_flag_i,
  input  wire logic [11:0] load_index_i,
  input  wire logic [15:0] load_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      program_counter_o,
  output logic             taken_o,
  output logic [15:0]      base_register_o
);

  localparam int unsigned DW = cbu_pkg::DATA_W;
  localparam int unsigned AW = cbu_pkg::MEM_AW;
  localparam int unsigned RW = cbu_pkg::REG_AW;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_MEM  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [1:0]    op_q;
  logic [2:0]    mode_q;
  logic [RW-1:0] rn_q;
  logic [7:0]    imm_q;
  logic          taken_q;

  logic [DW-1:0] reg_q [cbu_pkg::REG_COUNT];
  logic [DW-1:0] mem [cbu_pkg::MEM_WORDS];
  logic [DW-1:0] mem_rdata_q;

  logic          in_xfer;
  logic          out_free;
  logic          cond;
  logic [RW-1:0] in_rn;
  logic [DW-1:0] rn_val;
  logic [DW-1:0] pc_val;
  logic [DW-1:0] alu_a, alu_b, alu_sum;
  logic          reg_we;
  logic [RW-1:0] reg_waddr;
  logic [DW-1:0] reg_wdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] load_index_ext;

  logic          out_valid_q;
  logic [DW-1:0] out_pc_q;
  logic          out_taken_q;
  logic [DW-1:0] out_base_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_rn      = operand_i[RW-1:0];
  assign rn_val     = reg_q[rn_q];
  assign pc_val     = reg_q[cbu_pkg::PC_INDEX];

  // Branch condition on the incoming flags.
  always_comb begin
    unique case (branch_kind_i)
      cbu_pkg::BK_CC:     cond = !carry_flag_i;
      cbu_pkg::BK_CS:     cond = carry_flag_i;
      cbu_pkg::BK_EQ:     cond = zero_flag_i;
      cbu_pkg::BK_NE:     cond = !zero_flag_i;
      cbu_pkg::BK_LT:     cond = carry_flag_i;
      cbu_pkg::BK_LE:     cond = carry_flag_i || zero_flag_i;
      cbu_pkg::BK_GT:     cond = !carry_flag_i;
      cbu_pkg::BK_GE:     cond = !carry_flag_i || zero_flag_i;
      cbu_pkg::BK_ALWAYS: cond = 1'b1;
      default:            cond = 1'b0;
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a = pc_val;
    alu_b = mem_rdata_q;
    unique case (state_q)
      S_PRE: begin
        alu_a = rn_val;
        alu_b = cbu_pkg::NEG_STEP;
      end
      S_POST: begin
        alu_a = rn_val;
        alu_b = cbu_pkg::STEP;
      end
      S_ADD: begin
        alu_a = pc_val;
        if (mode_q == cbu_pkg::MODE_REG) begin
          alu_b = rn_val;
        end else if (mode_q == cbu_pkg::MODE_IMM) begin
          alu_b = {{(DW-8){1'b0}}, imm_q};
        end else begin
          alu_b = mem_rdata_q;
        end
      end
      default: begin
        alu_a = pc_val;
        alu_b = mem_rdata_q;
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b;

  // Register file write port: loads at the transfer, adder results in later steps.
  always_comb begin
    reg_we    = 1'b0;
    reg_waddr = rn_q;
    reg_wdata = alu_sum;
    unique case (state_q)
      S_IDLE: begin
        reg_we    = in_xfer && (op_i == cbu_pkg::OP_WRITE_REG);
        reg_waddr = load_index_i[RW-1:0];
        reg_wdata = load_value_i;
      end
      S_PRE, S_POST: begin
        reg_we    = 1'b1;
        reg_waddr = rn_q;
      end
      S_ADD: begin
        reg_we    = 1'b1;
        reg_waddr = cbu_pkg::PC_INDEX;
      end
      default: begin
        reg_we = 1'b0;
      end
    endcase
  end

  // Memory addresses are the low bits of the index or of the base register.
  assign load_index_ext = {{(DW-12){1'b0}}, load_index_i};
  assign mem_we         = in_xfer && (op_i == cbu_pkg::OP_WRITE_MEM);
  assign mem_waddr      = load_index_ext[AW-1:0];
  assign mem_raddr      = rn_val[AW-1:0];

  // Word memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= load_value_i;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  // Register file flip-flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbu_pkg::REG_COUNT; i++) begin
        reg_q[i] <= '0;
      end
    end else if (reg_we) begin
      reg_q[reg_waddr] <= reg_wdata;
    end
  end

  // Next step of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if ((op_i == cbu_pkg::OP_BRANCH) && cond && (mode_i <= cbu_pkg::MODE_IMM)) begin
            if (mode_i == cbu_pkg::MODE_PREDEC) begin
              state_d = S_PRE;
            end else if ((mode_i == cbu_pkg::MODE_IND) ||
                         (mode_i == cbu_pkg::MODE_POSTINC)) begin
              state_d = S_MEM;
            end else begin
              state_d = S_ADD;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PRE:  state_d = S_MEM;
      S_MEM:  state_d = S_ADD;
      S_ADD:  state_d = (mode_q == cbu_pkg::MODE_POSTINC) ? S_POST : S_DONE;
      S_POST: state_d = S_DONE;
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      taken_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        taken_q <= (op_i == cbu_pkg::OP_BRANCH) && cond && (mode_i <= cbu_pkg::MODE_IMM);
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item fields held for the length of the item.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= op_i;
      mode_q <= mode_i;
      rn_q   <= in_rn;
      imm_q  <= operand_i;
    end
  end

  // Output register, loaded when the previous result has been taken.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_pc_q    <= pc_val;
      out_taken_q <= taken_q;
      out_base_q  <= rn_val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign program_counter_o = out_pc_q;
  assign taken_o           = out_taken_q;
  assign base_register_o   = out_base_q;

  // A new result only appears out of the final step.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result appeared without a final step");

  // Only branch items can report a taken branch.
  a_taken_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && taken_q |-> op_q == cbu_pkg::OP_BRANCH)
    else $error("taken set for a non-branch item");

  // The increment follows the program counter update.
  a_post_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POST |-> $past(state_q) == S_ADD)
    else $error("increment step out of order");

  // Memory modes add only after the memory read has completed.
  a_add_after_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) && ((mode_q == cbu_pkg::MODE_PREDEC) || (mode_q == cbu_pkg::MODE_IND) ||
    (mode_q == cbu_pkg::MODE_POSTINC)) |-> $past(state_q) == S_MEM)
    else $error("memory displacement added before read");

endmodule

`default_nettype wire
